>>> rtl/prc_pkg.sv
// Shared types and constants for the pump run controller.
package prc_pkg;

    localparam int unsigned TicksPerMinute = 60;
    localparam int unsigned DefaultMinutes = 30;
    localparam int unsigned MaxMinutes     = 180;
    localparam int unsigned FullNeeded     = 4;
    localparam int unsigned EmptyNeeded    = 4;
    localparam int unsigned NodataNeeded   = 2;
    localparam int unsigned StopNeeded     = 5;
    localparam int unsigned FullSat        = 7;

    localparam int unsigned MinutesW = 8;
    localparam int unsigned TicksW   = 15;

    // Reciprocal of 60 scaled by 2**21; exact for every 15-bit tick count.
    localparam int unsigned RecipShift = 21;
    localparam int unsigned RecipW     = 16;
    localparam logic [RecipW-1:0] Recip60 = RecipW'(((1 << RecipShift) / TicksPerMinute) + 1);

    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_NODATA = 2'd2,
        KIND_OTHER  = 2'd3
    } t_report_kind;

    typedef enum logic [1:0] {
        STATUS_FULL   = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_NODATA = 2'd2
    } t_tank_status;

    typedef struct packed {
        logic         report_valid;
        t_report_kind report_kind;
        logic         button_pressed;
    } t_prc_in;

    typedef struct packed {
        logic                pump_on;
        t_tank_status        tank_status;
        logic [MinutesW-1:0] minutes_left;
    } t_prc_out;

    function automatic logic [TicksW-1:0] reload_ticks(input logic [MinutesW-1:0] minutes);
        logic [MinutesW-1:0] m;
        m = minutes;
        if (m == '0 || m > MinutesW'(MaxMinutes)) begin
            m = MinutesW'(DefaultMinutes);
        end
        return (TicksW'(m) << 6) - (TicksW'(m) << 2);
    endfunction

endpackage

>>> rtl/prc_if.sv
// Valid/ready channel interfaces for the tick input and the result output.
interface prc_in_if;
    import prc_pkg::*;
    logic    valid;
    logic    ready;
    t_prc_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface prc_out_if;
    import prc_pkg::*;
    logic     valid;
    logic     ready;
    t_prc_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pump_run_controller.sv
// Pump run controller: report streaks, button toggle and run-time countdown.
//
// The block takes one beat per control tick on i_in_ch: a report valid flag, a
// two-bit report kind and the button state. For each input beat it returns one
// beat on o_out_ch with the pump state, the tank status and the minutes left.
// The run limit in minutes is written through i_cfg_we and i_cfg_wdata; a new
// value is used at the next reload of the run time.
// All state but the run limit is updated at the edge that accepts an input
// beat, and the result is held in an output register, so it appears in the
// cycle after its input beat. One beat is accepted in every cycle, limited only
// by the output stage. When the receiver stalls, the output register holds its
// beat and the input stalls too, unless that beat is taken in the same cycle.
// The synchronous active-low reset stops the pump, loads 30 minutes as run
// limit and run time, clears all streaks, sets the status to no data and
// empties the output register.
module pump_run_controller
    import prc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MinutesW-1:0] i_cfg_wdata,
    prc_in_if.sink              i_in_ch,
    prc_out_if.source           o_out_ch
);

    logic [MinutesW-1:0] r_run_minutes;
    logic                r_running, n_running;
    logic [TicksW-1:0]   r_remaining, n_remaining;
    logic [2:0]          r_full_streak, n_full_streak;
    logic [2:0]          r_empty_streak, n_empty_streak;
    logic [1:0]          r_nodata_streak, n_nodata_streak;
    t_tank_status        r_level, n_level;
    logic [2:0]          r_stop_streak, n_stop_streak;

    logic                r_out_valid, n_out_valid;
    t_prc_out            r_out_data, n_out_data;

    logic                      in_accept;
    logic [TicksW-1:0]         reload;
    logic [TicksW+RecipW-1:0]  quot_product;
    logic [MinutesW-1:0]       minutes;

    assign i_in_ch.ready    = !r_out_valid || o_out_ch.ready;
    assign in_accept        = i_in_ch.valid && i_in_ch.ready;
    assign o_out_ch.valid   = r_out_valid;
    assign o_out_ch.payload = r_out_data;
    assign reload           = reload_ticks(r_run_minutes);

    always_comb begin
        n_running       = r_running;
        n_remaining     = r_remaining;
        n_full_streak   = r_full_streak;
        n_empty_streak  = r_empty_streak;
        n_nodata_streak = r_nodata_streak;
        n_level         = r_level;
        n_stop_streak   = r_stop_streak;

        if (i_in_ch.payload.report_valid) begin
            if (i_in_ch.payload.report_kind == KIND_FULL) begin
                if (n_full_streak < 3'(FullSat)) begin
                    n_full_streak = n_full_streak + 3'd1;
                end
                if (n_full_streak >= 3'(FullNeeded) && n_running) begin
                    n_running     = 1'b0;
                    n_remaining   = reload;
                    n_full_streak = '0;
                    n_level       = STATUS_FULL;
                end
            end else begin
                n_full_streak = '0;
            end

            if (i_in_ch.payload.report_kind == KIND_EMPTY) begin
                n_empty_streak = n_empty_streak + 3'd1;
                if (n_empty_streak >= 3'(EmptyNeeded)) begin
                    n_running      = 1'b1;
                    n_empty_streak = '0;
                    n_level        = STATUS_EMPTY;
                end
            end else begin
                n_empty_streak = '0;
            end

            if (i_in_ch.payload.report_kind == KIND_NODATA) begin
                n_nodata_streak = n_nodata_streak + 2'd1;
                if (n_nodata_streak >= 2'(NodataNeeded)) begin
                    n_nodata_streak = '0;
                    n_level         = STATUS_NODATA;
                end
            end else begin
                n_nodata_streak = '0;
            end
        end

        if (i_in_ch.payload.button_pressed) begin
            if (!n_running) begin
                n_running   = 1'b1;
                n_remaining = reload;
            end else begin
                n_running = 1'b0;
            end
        end

        if (n_running) begin
            if (n_remaining != '0) begin
                n_remaining = n_remaining - TicksW'(1);
            end
            if (n_remaining == '0 || n_level == STATUS_FULL) begin
                n_stop_streak = n_stop_streak + 3'd1;
                if (n_stop_streak >= 3'(StopNeeded)) begin
                    n_running     = 1'b0;
                    n_stop_streak = '0;
                    n_remaining   = reload;
                end
            end else begin
                n_stop_streak = '0;
            end
        end
    end

    // Minutes left is the tick count divided by 60, plus one.
    always_comb begin
        quot_product = (TicksW+RecipW)'(n_remaining) * (TicksW+RecipW)'(Recip60);
        minutes      = MinutesW'(quot_product >> RecipShift) + MinutesW'(1);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (in_accept) begin
            n_out_valid             = 1'b1;
            n_out_data.pump_on      = n_running;
            n_out_data.tank_status  = n_level;
            n_out_data.minutes_left = n_running ? minutes : '0;
        end else if (o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_minutes   <= MinutesW'(DefaultMinutes);
            r_running       <= 1'b0;
            r_remaining     <= reload_ticks(MinutesW'(DefaultMinutes));
            r_full_streak   <= '0;
            r_empty_streak  <= '0;
            r_nodata_streak <= '0;
            r_level         <= STATUS_NODATA;
            r_stop_streak   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_run_minutes <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_running       <= n_running;
                r_remaining     <= n_remaining;
                r_full_streak   <= n_full_streak;
                r_empty_streak  <= n_empty_streak;
                r_nodata_streak <= n_nodata_streak;
                r_level         <= n_level;
                r_stop_streak   <= n_stop_streak;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule
